// File: rtl/checksummed_frame_deframer_core_assert.svh
// Assertion macros for the deframer RTL; cfd_parser uses them.
`ifndef CHECKSUMMED_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define CHECKSUMMED_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Clocked on aclk and quiet while aresetn is low.
`define CFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked on aclk and also checked during reset.
`define CFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/cfd_pkg.sv
package cfd_pkg;

    // Default largest accepted payload length, in bytes.
    localparam int unsigned MAX_PAYLOAD_DEF = 1024;

    // Start byte value after reset.
    localparam logic [7:0] START_BYTE_RESET = 8'h01;

    // Parser phases, in frame order.
    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_ID_HI   = 4'd1,
        PH_ID_LO   = 4'd2,
        PH_LEN_HI  = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_KIND_HI = 4'd5,
        PH_KIND_LO = 4'd6,
        PH_CKH     = 4'd7,
        PH_DATA    = 4'd8,
        PH_CKD     = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_HDR_CKSUM  = 3'd1,
        ERR_LENGTH     = 3'd2,
        ERR_DATA_CKSUM = 3'd3,
        ERR_LINE       = 3'd4
    } err_code_t;

    // One result item as it travels from the parser to the output register.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [9:0]  payload_index;
        logic        header_done;
        logic        frame_done;
        err_code_t   error_code;
        logic [15:0] frame_ident;
        logic [10:0] frame_length;
        logic [15:0] frame_kind;
    } result_t;

endpackage

// File: rtl/cfd_parser.sv
`include "checksummed_frame_deframer_core_assert.svh"

module cfd_parser import cfd_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic [7:0] rx_byte,
    input  logic       line_error,
    input  logic [7:0] start_byte,
    output result_t    result
);

    localparam logic [16:0] MaxLen = 17'(MAX_PAYLOAD);

    phase_t      phase_reg, phase_next;
    logic [7:0]  hxor_reg, hxor_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] kind_reg, kind_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  pxor_reg, pxor_next;

    logic        hdr_ok;
    logic        len_ok;
    logic        data_ok;
    logic        is_start;
    logic [15:0] count_inc;
    logic        last_byte;

    assign hdr_ok    = (rx_byte == ~hxor_reg);
    assign len_ok    = ({1'b0, length_reg} <= MaxLen);
    assign data_ok   = (rx_byte == ~pxor_reg);
    assign is_start  = (rx_byte == start_byte);
    assign count_inc = count_reg + 16'd1;
    assign last_byte = (count_inc >= length_reg);

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (line_error) begin
            phase_next = PH_HUNT;
        end else begin
            unique case (phase_reg)
                PH_HUNT:    phase_next = is_start ? PH_ID_HI : PH_HUNT;
                PH_ID_HI:   phase_next = PH_ID_LO;
                PH_ID_LO:   phase_next = PH_LEN_HI;
                PH_LEN_HI:  phase_next = PH_LEN_LO;
                PH_LEN_LO:  phase_next = PH_KIND_HI;
                PH_KIND_HI: phase_next = PH_KIND_LO;
                PH_KIND_LO: phase_next = PH_CKH;
                PH_CKH: begin
                    if (!hdr_ok || !len_ok) begin
                        phase_next = PH_HUNT;
                    end else begin
                        phase_next = (length_reg != 16'd0) ? PH_DATA : PH_CKD;
                    end
                end
                PH_DATA:    phase_next = last_byte ? PH_CKD : PH_DATA;
                PH_CKD:     phase_next = PH_HUNT;
                default:    phase_next = PH_HUNT;
            endcase
        end
    end

    // Field capture, running checksums and the result item.
    always_comb begin
        hxor_next   = hxor_reg;
        ident_next  = ident_reg;
        length_next = length_reg;
        kind_next   = kind_reg;
        count_next  = count_reg;
        pxor_next   = pxor_reg;
        result      = '0;

        if (line_error) begin
            result.error_code = ERR_LINE;
            hxor_next   = '0;
            ident_next  = '0;
            length_next = '0;
            kind_next   = '0;
            count_next  = '0;
            pxor_next   = '0;
        end else begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (is_start) begin
                        hxor_next   = rx_byte;
                        ident_next  = '0;
                        length_next = '0;
                        kind_next   = '0;
                        count_next  = '0;
                        pxor_next   = '0;
                    end
                end
                PH_ID_HI, PH_ID_LO: begin
                    hxor_next  = hxor_reg ^ rx_byte;
                    ident_next = {ident_reg[7:0], rx_byte};
                end
                PH_LEN_HI, PH_LEN_LO: begin
                    hxor_next   = hxor_reg ^ rx_byte;
                    length_next = {length_reg[7:0], rx_byte};
                end
                PH_KIND_HI, PH_KIND_LO: begin
                    hxor_next = hxor_reg ^ rx_byte;
                    kind_next = {kind_reg[7:0], rx_byte};
                end
                PH_CKH: begin
                    if (!hdr_ok || !len_ok) begin
                        result.error_code = hdr_ok ? ERR_LENGTH : ERR_HDR_CKSUM;
                        hxor_next   = '0;
                        ident_next  = '0;
                        length_next = '0;
                        kind_next   = '0;
                        count_next  = '0;
                        pxor_next   = '0;
                    end else begin
                        result.header_done  = 1'b1;
                        result.frame_ident  = ident_reg;
                        result.frame_length = length_reg[10:0];
                        result.frame_kind   = kind_reg;
                        count_next = '0;
                        pxor_next  = '0;
                    end
                end
                PH_DATA: begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_byte;
                    result.payload_index = count_reg[9:0];
                    result.frame_ident   = ident_reg;
                    result.frame_length  = length_reg[10:0];
                    result.frame_kind    = kind_reg;
                    pxor_next  = pxor_reg ^ rx_byte;
                    count_next = count_inc;
                end
                PH_CKD: begin
                    result.frame_ident  = ident_reg;
                    result.frame_length = length_reg[10:0];
                    result.frame_kind   = kind_reg;
                    if (data_ok) begin
                        result.frame_done = 1'b1;
                    end else begin
                        result.error_code = ERR_DATA_CKSUM;
                    end
                    hxor_next   = '0;
                    ident_next  = '0;
                    length_next = '0;
                    kind_next   = '0;
                    count_next  = '0;
                    pxor_next   = '0;
                end
                default: begin
                    hxor_next   = '0;
                    ident_next  = '0;
                    length_next = '0;
                    kind_next   = '0;
                    count_next  = '0;
                    pxor_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            hxor_reg   <= '0;
            ident_reg  <= '0;
            length_reg <= '0;
            kind_reg   <= '0;
            count_reg  <= '0;
            pxor_reg   <= '0;
        end else if (take) begin
            phase_reg  <= phase_next;
            hxor_reg   <= hxor_next;
            ident_reg  <= ident_next;
            length_reg <= length_next;
            kind_reg   <= kind_next;
            count_reg  <= count_next;
            pxor_reg   <= pxor_next;
        end
    end

    `CFD_ASSERT(a_line_err_hunts, take && line_error |=> phase_reg == PH_HUNT && count_reg == 16'd0, "line error did not return to hunting")
    `CFD_ASSERT(a_hdr_to_body, take && result.header_done |=> phase_reg == PH_DATA || phase_reg == PH_CKD, "accepted header did not enter payload or data checksum")
    `CFD_ASSERT(a_count_in_range, phase_reg == PH_DATA |-> count_reg < length_reg, "payload counter ran past the frame length")
    `CFD_ASSERT_ALWAYS(a_one_event, $onehot0({result.payload_valid, result.header_done, result.frame_done, result.error_code != ERR_NONE}), "more than one event in a result item")

endmodule

// File: rtl/cfd_out_reg.sv
module cfd_out_reg import cfd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_result,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg, valid_next;
    result_t result_reg;

    // A new item may enter when the register is empty or the held one leaves in the same cycle.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// File: rtl/checksummed_frame_deframer_core.sv
// Frame deframer for a byte stream with header and data checksums.
// Input channel (s_valid/s_ready): one received byte per item, with a line
// error flag that drops the byte and sends the parser back to hunting.
// Result channel (m_valid/m_ready): exactly one result item per input item,
// carrying a payload byte and its index, header and frame completion flags,
// an error code, and the ID, length and type of the frame in progress.
// A result item is registered and shown on the cycle after its byte is
// accepted. Items are taken at one per cycle while the receiver does not
// stall; the parser state update and the single output register set that rate.
// The start byte register is written through cfg_wr_en/cfg_wr_data and
// should only be changed while the block is idle.
// When the receiver stalls, the output register holds its item and s_ready
// stays high only while that item leaves in the same cycle, so at most one
// result waits and nothing is lost.
// Reset (aresetn low, synchronous) empties the output register, puts the
// parser into the hunt phase with all fields cleared, and sets the start
// byte back to its reset value.
module checksummed_frame_deframer_core import cfd_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_line_error,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [9:0]  m_payload_index,
    output logic        m_header_done,
    output logic        m_frame_done,
    output logic [2:0]  m_error_code,
    output logic [15:0] m_frame_ident,
    output logic [10:0] m_frame_length,
    output logic [15:0] m_frame_kind
);

    logic [7:0] start_byte_reg;
    logic       take;
    result_t    parse_result;
    result_t    out_result;

    // The start byte is a plain write-only register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_BYTE_RESET;
        end else if (cfg_wr_en) begin
            start_byte_reg <= cfg_wr_data;
        end
    end

    // The parser state advances exactly when an item is accepted.
    assign take = s_valid && s_ready;

    cfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .rx_byte    (s_rx_byte),
        .line_error (s_line_error),
        .start_byte (start_byte_reg),
        .result     (parse_result)
    );

    // The output register decouples the receiver from the parser.
    cfd_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_result  (parse_result),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (out_result)
    );

    assign m_payload_valid = out_result.payload_valid;
    assign m_payload_byte  = out_result.payload_byte;
    assign m_payload_index = out_result.payload_index;
    assign m_header_done   = out_result.header_done;
    assign m_frame_done    = out_result.frame_done;
    assign m_error_code    = out_result.error_code;
    assign m_frame_ident   = out_result.frame_ident;
    assign m_frame_length  = out_result.frame_length;
    assign m_frame_kind    = out_result.frame_kind;

endmodule
